>>> rtl/core/hsv_rgb_led_channel_driver_assert.svh
// assertion macros for the hsv/rgb led channel driver
// no dependencies; expects clk and rst_n in the scope that uses them
`ifndef HSV_RGB_LED_CHANNEL_DRIVER_ASSERT_SVH
`define HSV_RGB_LED_CHANNEL_DRIVER_ASSERT_SVH

// checked only outside reset
`define HRLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HRLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/hrlcd_pkg.sv
// shared types and constants for the hsv/rgb led channel driver
// no dependencies
package hrlcd_pkg;

  localparam int BYTE_W  = 8;
  localparam int Q_W     = 17;
  localparam int MULB_W  = 33;
  localparam int PROD_W  = Q_W + MULB_W;
  localparam int SCALE_W = PROD_W + BYTE_W;

  localparam logic [Q_W-1:0]    Q_ONE  = 17'h1_0000;
  localparam logic [MULB_W-1:0] Q2_ONE = 33'h1_0000_0000;

  // item widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // mode codes
  localparam logic [1:0] MODE_RGB = 2'd0;
  localparam logic [1:0] MODE_HSV = 2'd1;
  localparam logic [1:0] MODE_OFF = 2'd2;

  // channel source codes
  localparam logic [1:0] SRC_RED   = 2'd0;
  localparam logic [1:0] SRC_GREEN = 2'd1;
  localparam logic [1:0] SRC_BLUE  = 2'd2;
  localparam logic [1:0] SRC_ZERO  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_RED_SRC   = 2'd0;
  localparam logic [1:0] REG_GREEN_SRC = 2'd1;
  localparam logic [1:0] REG_BLUE_SRC  = 2'd2;
  localparam logic [1:0] REG_INVERT    = 2'd3;

  // multiplier operand selections
  localparam logic [1:0] MUL_SF = 2'd0;  // sat * f
  localparam logic [1:0] MUL_VD = 2'd1;  // val * (1 - sat*f)
  localparam logic [1:0] MUL_VM = 2'd2;  // val * (1 - sat)

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_op;
    logic       bn_en;
    logic       bm_en;
    logic       out_en;
  } hrlcd_cmd_t;

endpackage

>>> rtl/core/hrlcd_ctrl.sv
// sequencer for the hsv/rgb led channel driver
// depends on hrlcd_pkg and the assertion macro header
`include "hsv_rgb_led_channel_driver_assert.svh"

module hrlcd_ctrl
  import hrlcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output hrlcd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SF   = 3'd1;
  localparam logic [2:0] S_VD   = 3'd2;
  localparam logic [2:0] S_VM   = 3'd3;
  localparam logic [2:0] S_BM   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.mul_op = MUL_SF;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SF;
        end
      end
      S_SF: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SF;
        state_nxt  = S_VD;
      end
      S_VD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_VD;
        state_nxt  = S_VM;
      end
      S_VM: begin
        // n is taken from the product before it is overwritten
        cmd.bn_en  = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_VM;
        state_nxt  = S_BM;
      end
      S_BM: begin
        cmd.bm_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HRLCD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "not idle after reset")
  `HRLCD_ASSERT(a_accept_starts, in_tvalid && in_tready |=> state_r == S_SF, "accepted item did not start")
  `HRLCD_ASSERT(a_no_overwrite, cmd.out_en |-> !out_valid_r || out_tready, "pending result overwritten")
  `HRLCD_ASSERT(a_result_shown, cmd.out_en |=> out_valid_r && (state_r == S_IDLE), "result not presented")

endmodule

>>> rtl/core/hrlcd_dp.sv
// datapath for the hsv/rgb led channel driver: operands, shared multiplier,
// colour selection, remap, inversion and change cache; depends on hrlcd_pkg
module hrlcd_dp
  import hrlcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  hrlcd_cmd_t            cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [1:0]            cfg_data,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // operand registers
  logic [1:0]              mode_r;
  logic [2:0][BYTE_W-1:0]  rgb_r;
  logic [Q_W-1:0]          sat_r, val_r, f_r;
  logic [2:0]              sec_r;
  logic                    hue_big_r;

  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [BYTE_W-1:0]       bn_r, bm_r;

  // configuration
  logic [1:0]              red_src_r, green_src_r, blue_src_r;
  logic                    invert_r;

  // change cache
  logic [2:0][BYTE_W-1:0]  last_r;
  logic [2:0]              written_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  // sector and fractional distance from the input hue
  logic [Q_W-1:0]          hue_in;
  logic [19:0]             h6;
  logic [Q_W-1:0]          frac_ext, f_in;

  assign hue_in   = in_tdata[40:24];
  assign h6       = {1'b0, hue_in, 2'b00} + {2'b00, hue_in, 1'b0};
  assign frac_ext = {1'b0, h6[15:0]};
  assign f_in     = h6[16] ? frac_ext : (Q_ONE - frac_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_tuser;
      rgb_r[0]  <= in_tdata[7:0];
      rgb_r[1]  <= in_tdata[15:8];
      rgb_r[2]  <= in_tdata[23:16];
      sat_r     <= in_tdata[57:41];
      val_r     <= in_tdata[74:58];
      sec_r     <= h6[18:16];
      f_r       <= f_in;
      hue_big_r <= (hue_in > Q_ONE);
    end
  end

  // shared multiplier, 17 x 33
  logic [Q_W-1:0]    mul_a;
  logic [MULB_W-1:0] mul_b;

  always_comb begin
    case (cmd.mul_op)
      MUL_SF: begin
        mul_a = sat_r;
        mul_b = {{(MULB_W-Q_W){1'b0}}, f_r};
      end
      MUL_VD: begin
        mul_a = val_r;
        mul_b = Q2_ONE - prod_r[MULB_W-1:0];
      end
      MUL_VM: begin
        mul_a = val_r;
        mul_b = {{(MULB_W-Q_W){1'b0}}, Q_ONE - sat_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a * mul_b);

  // x * 255 as (x << 8) - x, shared by n and m
  logic [SCALE_W-1:0] scaled;
  assign scaled = {prod_r, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, prod_r};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.bn_en) begin
      bn_r <= scaled[55:48];
    end
    if (cmd.bm_en) begin
      bm_r <= scaled[39:32];
    end
  end

  logic [24:0]       val_scaled;
  logic [BYTE_W-1:0] bv;
  assign val_scaled = {val_r, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, val_r};
  assign bv         = val_scaled[23:16];

  // colour selection
  logic [2:0][BYTE_W-1:0] hsv_col, raw, duty;
  logic [2:0][1:0]        src;
  logic                   black;

  assign black = (sat_r > Q_ONE) || (val_r > Q_ONE);

  always_comb begin
    if (black) begin
      hsv_col = '0;
    end else if (hue_big_r) begin
      hsv_col = {bv, bv, bv};
    end else begin
      case (sec_r)
        3'd1:    hsv_col = {bm_r, bv, bn_r};
        3'd2:    hsv_col = {bn_r, bv, bm_r};
        3'd3:    hsv_col = {bv, bn_r, bm_r};
        3'd4:    hsv_col = {bv, bm_r, bn_r};
        3'd5:    hsv_col = {bn_r, bm_r, bv};
        default: hsv_col = {bm_r, bn_r, bv};  // sectors zero and six
      endcase
    end
  end

  assign raw    = (mode_r == MODE_RGB) ? rgb_r : hsv_col;
  assign src[0] = red_src_r;
  assign src[1] = green_src_r;
  assign src[2] = blue_src_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [BYTE_W-1:0] pick;
      case (src[c])
        SRC_RED:   pick = raw[0];
        SRC_GREEN: pick = raw[1];
        SRC_BLUE:  pick = raw[2];
        default:   pick = '0;
      endcase
      if (mode_r != MODE_RGB && mode_r != MODE_HSV) begin
        duty[c] = '0;  // off and the unused mode bypass remap and inversion
      end else if (invert_r) begin
        duty[c] = ~pick;
      end else begin
        duty[c] = pick;
      end
    end
  end

  logic [2:0] strobe;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      strobe[c] = !written_r[c] || (last_r[c] != duty[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      out_data_r <= {5'b0, strobe, duty[2], duty[1], duty[0]};
      last_r     <= duty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (cmd.out_en) begin
      written_r <= '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_src_r   <= SRC_RED;
      green_src_r <= SRC_GREEN;
      blue_src_r  <= SRC_BLUE;
      invert_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_SRC:   red_src_r   <= cfg_data;
        REG_GREEN_SRC: green_src_r <= cfg_data;
        REG_BLUE_SRC:  blue_src_r  <= cfg_data;
        REG_INVERT:    invert_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  assign out_tdata = out_data_r;

endmodule

>>> rtl/core/hsv_rgb_led_channel_driver.sv
// top level of the hsv/rgb led channel driver
// depends on hrlcd_pkg, hrlcd_ctrl and hrlcd_dp

// Drives three LED PWM duty bytes from one item at a time. An item carries a
// mode in tuser (direct RGB, HSV through the six-sector hexcone rule, or off)
// and both colour forms in tdata; HSV fields are unsigned Q1.16. Each item
// gives exactly one result: three duty bytes after the per-channel source
// remap and optional inversion (off gives zeros untouched), plus a change
// strobe per channel that is high when the duty differs from the last one
// output, or when that channel has not been written since reset. An item is
// accepted only while the sequencer is idle: it is taken, then makes three
// passes through a single shared 17 x 33 multiplier, then steps of scaling
// and selection; the result register frees the input side, so the next
// item is taken while a result still waits, and only a result that is not
// taken by the time the next one is ready holds the sequencer. Register
// writes must be made while no item is in flight.
module hsv_rgb_led_channel_driver
  import hrlcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // red_in, green_in, blue_in, hue, saturation, brightness, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out, green_out, blue_out, red_write, green_write, blue_write, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // register writes
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [1:0]            cfg_data
);

  hrlcd_cmd_t cmd;

  // sequencer: handshakes and step commands
  hrlcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic, colour path, change cache and registers
  hrlcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

>>> verif/hsv_rgb_led_channel_driver_tb.sv
// testbench for the hsv/rgb led channel driver: directed, register and random tests
// depends on hrlcd_pkg and hsv_rgb_led_channel_driver; self-checking, no files
module hsv_rgb_led_channel_driver_tb;
  import hrlcd_pkg::*;

  // the block treats the spare mode code as off
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // cycles with no item moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 1000;

  // one input item, fields as they travel on the input side
  typedef struct packed {
    logic [1:0]      mode;
    logic [BYTE_W-1:0] red_in;
    logic [BYTE_W-1:0] green_in;
    logic [BYTE_W-1:0] blue_in;
    logic [Q_W-1:0]  hue;
    logic [Q_W-1:0]  saturation;
    logic [Q_W-1:0]  brightness;
  } led_item_t;

  // one result: duty bytes and change strobes, index 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0]              strobe;
    logic [2:0][BYTE_W-1:0]  duty;
  } duty_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = MODE_RGB;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_RED_SRC;
  logic [1:0]            cfg_data = '0;

  hsv_rgb_led_channel_driver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers and of the change cache
  logic [1:0]        src_sel [3] = '{SRC_RED, SRC_GREEN, SRC_BLUE};
  logic              invert_on = 1'b0;
  logic [BYTE_W-1:0] last_duty [3] = '{8'd0, 8'd0, 8'd0};
  logic              duty_seen [3] = '{1'b0, 1'b0, 1'b0};

  // duties still owed by the block, oldest first
  duty_result_t due_duties [$];

  // run statistics and flow control
  int  failures = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_hsv = 0;
  int  n_grey = 0;
  int  n_black = 0;
  int  n_unchanged = 0;
  int  n_writes = 0;
  int  burst_left = 0;
  int  rx_run = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  string chan_name [3] = '{"red", "green", "blue"};
  duty_result_t got_duty;
  duty_result_t want_duty;

  // six-sector hexcone conversion, exact in 64-bit integers
  function automatic logic [2:0][BYTE_W-1:0] convert_hexcone(
    logic [Q_W-1:0] h, logic [Q_W-1:0] s, logic [Q_W-1:0] v);
    logic [63:0] h6, sector, frac, f, bv, bm, bn;
    logic [2:0][BYTE_W-1:0] c;
    // saturation or value above one is black
    if (s > Q_ONE || v > Q_ONE) begin
      n_black++;
      return '0;
    end
    bv = (64'(v) * 64'd255) >> 16;
    // hue beyond one full turn is grey at the given value
    if (h > Q_ONE) begin
      n_grey++;
      return {3{bv[BYTE_W-1:0]}};
    end
    h6 = 64'(h) * 64'd6;
    sector = h6 >> 16;
    frac = h6 & 64'hFFFF;
    f = sector[0] ? frac : 64'd65536 - frac;
    bm = (64'(v) * (64'd65536 - 64'(s)) * 64'd255) >> 32;
    bn = (64'(v) * ((64'd1 << 32) - 64'(s) * f) * 64'd255) >> 48;
    // sector six is hue exactly one and falls in with sector zero
    case (sector)
      64'd1: c = {bm[7:0], bv[7:0], bn[7:0]};
      64'd2: c = {bn[7:0], bv[7:0], bm[7:0]};
      64'd3: c = {bv[7:0], bn[7:0], bm[7:0]};
      64'd4: c = {bv[7:0], bm[7:0], bn[7:0]};
      64'd5: c = {bn[7:0], bm[7:0], bv[7:0]};
      default: c = {bm[7:0], bn[7:0], bv[7:0]};
    endcase
    return c;
  endfunction

  // duties and strobes for one accepted item; moves the change cache on
  function automatic duty_result_t predict_duties(led_item_t it);
    logic [2:0][BYTE_W-1:0] raw;
    logic [2:0][BYTE_W-1:0] duty;
    logic [BYTE_W-1:0] x;
    duty_result_t r;
    raw = '0;
    duty = '0;
    if (it.mode == MODE_RGB) begin
      raw = {it.blue_in, it.green_in, it.red_in};
    end else if (it.mode == MODE_HSV) begin
      n_hsv++;
      raw = convert_hexcone(it.hue, it.saturation, it.brightness);
    end
    // off and the spare mode skip remap and inversion entirely
    if (it.mode == MODE_RGB || it.mode == MODE_HSV) begin
      for (int c = 0; c < 3; c++) begin
        x = '0;
        case (src_sel[c])
          SRC_RED:   x = raw[0];
          SRC_GREEN: x = raw[1];
          SRC_BLUE:  x = raw[2];
          SRC_ZERO:  x = '0;
        endcase
        duty[c] = invert_on ? 8'd255 - x : x;
      end
    end
    for (int c = 0; c < 3; c++) begin
      r.duty[c] = duty[c];
      r.strobe[c] = !duty_seen[c] || last_duty[c] != duty[c];
      last_duty[c] = duty[c];
      duty_seen[c] = 1'b1;
    end
    if (r.strobe == 3'b000) n_unchanged++;
    return r;
  endfunction

  // sends one item; valid stays up within a burst and drops for a random gap after it
  task automatic send_colour(led_item_t it);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = it.mode;
    in_tdata = {5'b0, it.brightness, it.saturation, it.hue,
                it.blue_in, it.green_in, it.red_in};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due_duties.push_back(predict_duties(it));
    n_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // lowers valid before anything other than another item follows
  task automatic hold_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (due_duties.size() != 0) @(posedge clk);
  endtask

  // register write once the block has nothing in flight
  task automatic write_setting(logic [1:0] idx, logic [1:0] val);
    hold_input();
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RED_SRC:   src_sel[0] = val;
      REG_GREEN_SRC: src_sel[1] = val;
      REG_BLUE_SRC:  src_sel[2] = val;
      REG_INVERT:    invert_on = val[0];
    endcase
    n_writes++;
  endtask

  task automatic write_all(logic [1:0] r, logic [1:0] g, logic [1:0] b, logic inv);
    write_setting(REG_RED_SRC, r);
    write_setting(REG_GREEN_SRC, g);
    write_setting(REG_BLUE_SRC, b);
    write_setting(REG_INVERT, {1'b0, inv});
  endtask

  // item builders; the fields the mode ignores carry random values
  function automatic led_item_t make_rgb(logic [1:0] mode, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
    led_item_t it;
    it.mode = mode;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    it.hue = Q_W'($urandom);
    it.saturation = Q_W'($urandom);
    it.brightness = Q_W'($urandom);
    return it;
  endfunction

  function automatic led_item_t make_hsv(logic [Q_W-1:0] h, logic [Q_W-1:0] s,
                                         logic [Q_W-1:0] v);
    led_item_t it;
    it = make_rgb(MODE_HSV, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    it.hue = h;
    it.saturation = s;
    it.brightness = v;
    return it;
  endfunction

  // random item: mostly valid hsv and rgb, some out-of-range fields, off and spare modes
  function automatic led_item_t random_item();
    led_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return make_rgb(MODE_RGB, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    end
    if (pick < 88) begin
      it = make_hsv(Q_W'($urandom_range(0, Q_ONE)), Q_W'($urandom_range(0, Q_ONE)),
                    Q_W'($urandom_range(0, Q_ONE)));
      case ($urandom_range(0, 9))
        0: it.hue = Q_W'(($urandom_range(0, 6) * 65536) / 6);  // sector boundaries
        1: it.saturation = Q_ONE;
        2: it.brightness = Q_ONE;
        3: it.hue = Q_W'($urandom);                              // full 17-bit range
        4: it.saturation = Q_W'($urandom);
        5: it.brightness = Q_W'($urandom);
        default: ;
      endcase
      return it;
    end
    if (pick < 96) begin
      return make_rgb(MODE_OFF, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    end
    return make_rgb(MODE_SPARE, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
  endfunction

  // direct bytes at the extremes, unchanged duties, off and the spare mode
  task automatic test_rgb_direct();
    // first item after reset: all strobes up even for zero duties
    send_colour(make_rgb(MODE_RGB, 8'd0, 8'd0, 8'd0));
    send_colour(make_rgb(MODE_RGB, 8'd255, 8'd255, 8'd255));
    send_colour(make_rgb(MODE_RGB, 8'd1, 8'd128, 8'd254));
    send_colour(make_rgb(MODE_RGB, 8'd1, 8'd128, 8'd254));
    send_colour(make_rgb(MODE_OFF, 8'd200, 8'd100, 8'd50));
    send_colour(make_rgb(MODE_SPARE, 8'd255, 8'd255, 8'd255));
    send_colour(make_rgb(MODE_OFF, 8'd7, 8'd7, 8'd7));
  endtask

  // hsv edges: hue of one and beyond, saturation and value out of range, each sector
  task automatic test_hsv_special_cases();
    send_colour(make_hsv('0, Q_ONE, Q_ONE));
    send_colour(make_hsv(Q_ONE, Q_ONE, Q_ONE));
    send_colour(make_hsv(Q_ONE + 17'd1, 17'h0_8000, Q_ONE));
    send_colour(make_hsv(17'h1_FFFF, 17'h1_FFFF - 17'h1_0000, 17'h0_C000));
    send_colour(make_hsv(17'h0_4000, Q_ONE + 17'd1, Q_ONE));
    send_colour(make_hsv(17'h0_4000, Q_ONE, 17'h1_FFFF));
    send_colour(make_hsv(17'h0_9000, '0, 17'h0_A000));
    send_colour(make_hsv(17'h0_9000, Q_ONE, '0));
    for (int k = 0; k < 6; k++) begin
      send_colour(make_hsv(17'((2 * k + 1) * 65536 / 12), 17'h0_C000, 17'h0_E000));
    end
  endtask

  // several source and inversion settings, the extremes among them
  task automatic test_source_settings();
    logic [1:0] setting [6][4] = '{
      '{SRC_ZERO,  SRC_ZERO,  SRC_ZERO,  2'd1},
      '{SRC_ZERO,  SRC_ZERO,  SRC_ZERO,  2'd0},
      '{SRC_BLUE,  SRC_GREEN, SRC_RED,   2'd1},
      '{SRC_BLUE,  SRC_BLUE,  SRC_BLUE,  2'd0},
      '{SRC_GREEN, SRC_ZERO,  SRC_RED,   2'd1},
      '{SRC_RED,   SRC_GREEN, SRC_BLUE,  2'd0}
    };
    for (int s = 0; s < 6; s++) begin
      write_all(setting[s][0], setting[s][1], setting[s][2], setting[s][3][0]);
      for (int i = 0; i < 40; i++) send_colour(random_item());
    end
  endtask

  // sender waits for every outstanding result before the next item
  task automatic test_flow_pressure();
    for (int i = 0; i < 30; i++) begin
      send_colour(random_item());
      hold_input();
      wait_drained();
    end
  endtask

  // bulk random items in blocks, some with no idling, settings changed now and then
  task automatic test_random_mix();
    led_item_t prev_item;
    led_item_t it;
    prev_item = random_item();
    for (int blk = 0; blk < 14; blk++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (blk % 3 == 2) begin
        write_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < 100; i++) begin
        // repeats keep the unchanged-duty path busy
        it = ($urandom_range(0, 4) == 0) ? prev_item : random_item();
        send_colour(it);
        prev_item = it;
      end
    end
    steady = 1'b0;
  endtask

  // receiver: alternating ready and stall runs of random length, always ready when steady
  always @(negedge clk) begin
    if (!rst_n || steady) begin
      out_tready <= 1'b1;
      rx_run <= 0;
    end else if (rx_run == 0) begin
      out_tready <= ~out_tready;
      rx_run <= out_tready ? $urandom_range(0, 12) : $urandom_range(0, 20);
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  // result check against the oldest outstanding prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_duty = out_tdata[26:0];
      if (due_duties.size() == 0) begin
        failures++;
        $error("result with no item outstanding: tdata %h", out_tdata);
      end else begin
        want_duty = due_duties.pop_front();
        n_checked++;
        for (int c = 0; c < 3; c++) begin
          if (got_duty.duty[c] !== want_duty.duty[c]) begin
            failures++;
            $error("%s_out: expected %0d, got %0d", chan_name[c],
                   want_duty.duty[c], got_duty.duty[c]);
          end
          if (got_duty.strobe[c] !== want_duty.strobe[c]) begin
            failures++;
            $error("%s_write: expected %0b, got %0b", chan_name[c],
                   want_duty.strobe[c], got_duty.strobe[c]);
          end
        end
      end
    end
  end

  // watchdog on cycles in which no item moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, due_duties.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_rgb_direct();
    test_hsv_special_cases();
    test_source_settings();
    test_flow_pressure();
    test_random_mix();

    // let the last results come out, then a short quiet spell for strays
    hold_input();
    wait_drained();
    repeat (20) @(posedge clk);
    if (due_duties.size() != 0) begin
      failures++;
      $error("%0d results never arrived", due_duties.size());
    end

    $display("%0d items sent, %0d results checked, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("hsv items %0d (grey %0d, black %0d), unchanged results %0d, failures %0d",
             n_hsv, n_grey, n_black, n_unchanged, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
